@@ design/assert_macros.svh @@
// assertion helpers shared by the dns responder modules
// expects signals named clk and rst_n in the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold whenever the trigger holds, same edge
`define ASSERT_SAME(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error(msg);

// condition must hold on the edge after the trigger
`define ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

@@ design/dqfa_pkg.sv @@
// shared types, constants and the answer table of the dns a-record responder
// no dependencies
`default_nettype none

package dqfa_pkg;

  localparam int MAX_PAYLOAD_DEF = 512;
  localparam int HEADER_LEN      = 12;

  // header byte positions that get rewritten or inspected
  localparam int POS_FLAGS_HI = 2;
  localparam int POS_FLAGS_LO = 3;
  localparam int POS_QD_HI    = 4;
  localparam int POS_QD_LO    = 5;
  localparam int POS_AN_HI    = 6;
  localparam int POS_AN_LO    = 7;
  localparam int POS_NS_HI    = 8;

  localparam logic [7:0] FLAGS_HI_BYTE = 8'h81;
  localparam logic [7:0] FLAGS_LO_BYTE = 8'h80;
  localparam logic [7:0] ANSWER_COUNT  = 8'h01;

  // type and class follow the name terminator
  localparam int QTAIL_LEN = 5;

  localparam int ANSWER_LEN = 16;
  localparam logic [3:0] ANSWER_LAST_IDX = 4'(ANSWER_LEN - 1);

  // one parsed item handed from parser to emitter
  typedef struct packed {
    logic       echo;
    logic [7:0] data;
    logic       is_last;
    logic       drop;
  } desc_t;

  // byte of the appended answer record at a given index
  function automatic logic [7:0] answer_byte(input logic [3:0] idx,
                                             input logic [31:0] addr);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'hC0;
      4'd1:    b = 8'h0C;
      4'd2:    b = 8'h00;
      4'd3:    b = 8'h01;
      4'd4:    b = 8'h00;
      4'd5:    b = 8'h01;
      4'd6:    b = 8'h00;
      4'd7:    b = 8'h00;
      4'd8:    b = 8'h00;
      4'd9:    b = 8'h3C;
      4'd10:   b = 8'h00;
      4'd11:   b = 8'h04;
      4'd12:   b = addr[31:24];
      4'd13:   b = addr[23:16];
      4'd14:   b = addr[15:8];
      4'd15:   b = addr[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

@@ design/dqfa_intf.sv @@
// channel interfaces of the dns responder: query bytes, reply bytes, config
// no dependencies
`default_nettype none

interface dqfa_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface dqfa_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       drop;
  modport source (output valid, output out_byte, output out_last, output drop,
                  input ready);
  modport sink   (input valid, input out_byte, input out_last, input drop,
                  output ready);
endinterface

interface dqfa_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] answer_address;
  modport source (output valid, output answer_address, input ready);
  modport sink   (input valid, input answer_address, output ready);
endinterface

`default_nettype wire

@@ design/dqfa_parser.sv @@
// per-byte query parser: header rewrite, label walk, drop decision
// depends on dqfa_pkg, dqfa_intf.sv and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module dqfa_parser #(
  parameter int MAX_PAYLOAD = dqfa_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  dqfa_in_if.sink            in_ch,
  output dqfa_pkg::desc_t    desc,
  output logic               desc_valid,
  input  wire logic          desc_take
);
  import dqfa_pkg::*;

  localparam int POS_W = $clog2(MAX_PAYLOAD + 2);
  localparam int SUM_W = $clog2(MAX_PAYLOAD + 257);
  localparam logic [POS_W-1:0] MAX_POS  = POS_W'(MAX_PAYLOAD);
  localparam logic [SUM_W-1:0] MAX_SUM  = SUM_W'(MAX_PAYLOAD);
  localparam logic [SUM_W-1:0] QEND_SAT = SUM_W'(MAX_PAYLOAD + 1);
  localparam logic [POS_W-1:0] HDR_POS  = POS_W'(HEADER_LEN);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] nlp_r, nlp_nxt;
  logic             name_ended_r, name_ended_nxt;
  logic [POS_W-1:0] qend_r, qend_nxt;
  logic             qcn_r, qcn_nxt;
  logic             desc_valid_r, desc_valid_nxt;
  desc_t            desc_r, desc_nxt;

  logic             accept;
  logic             echo;
  logic [7:0]       eb;
  logic             dropit;
  logic [SUM_W-1:0] label_sum;
  logic [SUM_W-1:0] qend_sum;

  assign in_ch.ready = !desc_valid_r || desc_take;
  assign accept      = in_ch.valid && in_ch.ready;
  assign desc        = desc_r;
  assign desc_valid  = desc_valid_r;

  assign label_sum = SUM_W'(pos_r) + SUM_W'(in_ch.in_byte) + SUM_W'(1);
  assign qend_sum  = SUM_W'(pos_r) + SUM_W'(QTAIL_LEN);

  // byte classification and state update for the offered item
  always_comb begin
    pos_nxt        = pos_r;
    nlp_nxt        = nlp_r;
    name_ended_nxt = name_ended_r;
    qend_nxt       = qend_r;
    qcn_nxt        = qcn_r;
    echo           = 1'b0;
    eb             = in_ch.in_byte;
    if (pos_r < MAX_POS) begin
      if (pos_r < HDR_POS) begin
        echo = 1'b1;
        if (pos_r == POS_W'(POS_FLAGS_HI)) begin
          eb = FLAGS_HI_BYTE;
        end else if (pos_r == POS_W'(POS_FLAGS_LO)) begin
          eb = FLAGS_LO_BYTE;
        end else if (pos_r == POS_W'(POS_QD_HI) || pos_r == POS_W'(POS_QD_LO)) begin
          if (in_ch.in_byte != 8'h00) qcn_nxt = 1'b1;
        end else if (pos_r == POS_W'(POS_AN_HI)) begin
          eb = 8'h00;
        end else if (pos_r == POS_W'(POS_AN_LO)) begin
          eb = ANSWER_COUNT;
        end else if (pos_r >= POS_W'(POS_NS_HI)) begin
          eb = 8'h00;
        end
      end else if (!name_ended_r) begin
        echo = 1'b1;
        if (pos_r == nlp_r) begin
          if (in_ch.in_byte == 8'h00) begin
            name_ended_nxt = 1'b1;
            qend_nxt = (qend_sum > QEND_SAT) ? POS_W'(QEND_SAT) : POS_W'(qend_sum);
          end else begin
            nlp_nxt = (label_sum > MAX_SUM) ? MAX_POS : POS_W'(label_sum);
          end
        end
      end else if (pos_r < qend_r) begin
        echo = 1'b1;
      end
      pos_nxt = pos_r + POS_W'(1);
    end
    dropit = (pos_nxt < HDR_POS) || !qcn_nxt || !name_ended_nxt || (qend_nxt > pos_nxt);
  end

  // descriptor slot toward the emitter
  always_comb begin
    desc_valid_nxt = desc_valid_r;
    desc_nxt       = desc_r;
    if (desc_take) desc_valid_nxt = 1'b0;
    if (accept) begin
      desc_valid_nxt   = in_ch.in_last || echo;
      desc_nxt.echo    = echo;
      desc_nxt.data    = (in_ch.in_last && dropit) ? 8'h00 : eb;
      desc_nxt.is_last = in_ch.in_last;
      desc_nxt.drop    = in_ch.in_last && dropit;
    end
  end

  // packet state, cleared after each final byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      nlp_r        <= HDR_POS;
      name_ended_r <= 1'b0;
      qend_r       <= '0;
      qcn_r        <= 1'b0;
      desc_valid_r <= 1'b0;
    end else begin
      desc_valid_r <= desc_valid_nxt;
      if (accept) begin
        if (in_ch.in_last) begin
          pos_r        <= '0;
          nlp_r        <= HDR_POS;
          name_ended_r <= 1'b0;
          qend_r       <= '0;
          qcn_r        <= 1'b0;
        end else begin
          pos_r        <= pos_nxt;
          nlp_r        <= nlp_nxt;
          name_ended_r <= name_ended_nxt;
          qend_r       <= qend_nxt;
          qcn_r        <= qcn_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    desc_r <= desc_nxt;
  end

  // non-final descriptors only exist for echoed bytes
  `ASSERT_SAME(a_desc_echo, desc_valid_r && !desc_r.is_last, desc_r.echo,
               "parser queued a non-final item that is not echoed")
  // final byte resets the packet position
  `ASSERT_NEXT(a_last_clears, accept && in_ch.in_last, pos_r == '0,
               "byte position not cleared after final byte")

endmodule

`default_nettype wire

@@ design/dqfa_emitter.sv @@
// reply emitter: output register and 16-byte answer sequencer
// depends on dqfa_pkg, dqfa_intf.sv and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module dqfa_emitter (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dqfa_pkg::desc_t   desc,
  input  wire logic              desc_valid,
  output logic                   desc_take,
  input  wire logic [31:0]       answer_address,
  dqfa_out_if.source             out_ch
);
  import dqfa_pkg::*;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_last_r, out_last_nxt;
  logic       out_drop_r, out_drop_nxt;
  logic       seq_active_r, seq_active_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign desc_take = !seq_active_r && desc_valid && out_free;

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.out_last = out_last_r;
  assign out_ch.drop     = out_drop_r;

  // pick the next reply item: answer byte, echoed byte or drop marker
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_byte_nxt   = out_byte_r;
    out_last_nxt   = out_last_r;
    out_drop_nxt   = out_drop_r;
    seq_active_nxt = seq_active_r;
    cnt_nxt        = cnt_r;
    if (out_free) begin
      out_valid_nxt = 1'b0;
      if (seq_active_r) begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = answer_byte(cnt_r, answer_address);
        out_last_nxt  = (cnt_r == ANSWER_LAST_IDX);
        out_drop_nxt  = 1'b0;
        cnt_nxt       = cnt_r + 4'd1;
        if (cnt_r == ANSWER_LAST_IDX) seq_active_nxt = 1'b0;
      end else if (desc_valid) begin
        out_valid_nxt = 1'b1;
        out_drop_nxt  = 1'b0;
        out_last_nxt  = 1'b0;
        out_byte_nxt  = desc.data;
        if (desc.is_last && desc.drop) begin
          out_byte_nxt = 8'h00;
          out_last_nxt = 1'b1;
          out_drop_nxt = 1'b1;
        end else if (desc.is_last) begin
          seq_active_nxt = 1'b1;
          if (desc.echo) begin
            cnt_nxt = 4'd0;
          end else begin
            out_byte_nxt = answer_byte(4'd0, answer_address);
            cnt_nxt      = 4'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      seq_active_r <= 1'b0;
      cnt_r        <= 4'd0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      seq_active_r <= seq_active_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_drop_r <= out_drop_nxt;
  end

  // a drop marker always closes the packet
  `ASSERT_SAME(a_drop_last, out_valid_r && out_drop_r, out_last_r,
               "drop marker without last flag")
  // the last answer byte ends the sequencer
  `ASSERT_SAME(a_last_idle, out_valid_r && out_last_r && !out_drop_r, !seq_active_r,
               "answer sequence still running after last byte")

endmodule

`default_nettype wire

@@ design/dns_query_to_fixed_a_answer.sv @@
// top level of the dns responder that answers every query with one a record
// depends on dqfa_pkg, dqfa_intf.sv, dqfa_parser and dqfa_emitter
`default_nettype none

// Query bytes are taken one per clock while the reply side keeps up and no
// answer record is being sent; each byte passes the parser's position
// compare and label add into a one-item descriptor register and then the
// emitter's output register. The final byte of a good packet makes the
// emitter send its echo, if any, and then the 16-byte answer record
// through its single output register; the input is held off once the
// descriptor register fills. A dropped packet ends with one marker item.
// The answer address is read live from the config register at emit time.
module dns_query_to_fixed_a_answer #(
  parameter int MAX_PAYLOAD = dqfa_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  dqfa_in_if.sink    in_ch,
  dqfa_out_if.source out_ch,
  dqfa_cfg_if.sink   cfg_ch
);
  import dqfa_pkg::*;

  desc_t       desc;
  logic        desc_valid;
  logic        desc_take;
  logic [31:0] answer_address_r;

  // config register, always ready
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      answer_address_r <= 32'h0;
    end else if (cfg_ch.valid) begin
      answer_address_r <= cfg_ch.answer_address;
    end
  end

  dqfa_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .desc       (desc),
    .desc_valid (desc_valid),
    .desc_take  (desc_take)
  );

  dqfa_emitter u_emitter (
    .clk            (clk),
    .rst_n          (rst_n),
    .desc           (desc),
    .desc_valid     (desc_valid),
    .desc_take      (desc_take),
    .answer_address (answer_address_r),
    .out_ch         (out_ch)
  );

endmodule

`default_nettype wire

@@ sim/tb_dns_query_to_fixed_a_answer.sv @@
`timescale 1ns / 100ps
// self-checking testbench of dns_query_to_fixed_a_answer: drives query bytes, predicts reply
// bytes and compares them; depends on dqfa_pkg, the channel interfaces in dqfa_intf.sv and the rtl

module tb_dns_query_to_fixed_a_answer;
  import dqfa_pkg::*;

  localparam int PAYLOAD_LIMIT = MAX_PAYLOAD_DEF;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_LIMIT   = 4000;
  localparam int MAX_REPORTS   = 10;

  // fixed part of the appended a record, the address follows it
  localparam logic [95:0] ANSWER_HEAD = 96'hC00C_0001_0001_0000_003C_0004;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       drop;
  } reply_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       typed;
    reply_t     reply;
  } query_row_t;

  typedef enum int {
    QK_GOOD, QK_NO_QUESTION, QK_TRUNCATED, QK_FAR_LABEL, QK_NOISE
  } query_kind_e;

  logic clk;
  logic rst_n;

  dqfa_in_if  in_ch ();
  dqfa_out_if out_ch ();
  dqfa_cfg_if cfg_ch ();

  dns_query_to_fixed_a_answer i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // parser state of the predictor
  logic [9:0]  byte_pos;
  logic [9:0]  label_pos;
  bit          name_done;
  logic [9:0]  q_end;
  bit          qd_nonzero;
  logic [31:0] answer_addr_model;

  reply_t      reply_step [17];
  reply_t      expected_replies [$];
  logic [7:0]  query_bytes [$];
  reply_t      seen_reply;
  reply_t      want_reply;
  int          mismatch_count;
  int          quiet_cycles;
  int          tx_idle_pct;
  int          rx_idle_pct;
  bit          hold_req;
  int          hold_left;

  // directed queries: short after reset, minimal good query at field extremes, no question
  query_row_t query_table [30] = '{
    '{8'hFF, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1}},
    '{8'hFF, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0}, '{8'h01, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0}, '{8'h01, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0}, '{8'h01, 1'b1, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1}}
  };

  function automatic void clear_query_state();
    byte_pos   = '0;
    label_pos  = 10'(HEADER_LEN);
    name_done  = 1'b0;
    q_end      = '0;
    qd_nonzero = 1'b0;
  endfunction

  // reply items caused by one query byte, left in reply_step; returns their count
  function automatic int predict_reply(input logic [7:0] b, input logic last);
    int           pos;
    int           len;
    int           n;
    int           nx;
    int           i;
    bit           echo;
    bit           dropit;
    logic [7:0]   eb;
    logic [127:0] record;
    pos  = byte_pos;
    n    = 0;
    echo = 1'b0;
    eb   = b;
    if (pos < PAYLOAD_LIMIT) begin
      if (pos < HEADER_LEN) begin
        // header echo with flag and count rewrites
        echo = 1'b1;
        if (pos == POS_FLAGS_HI) eb = FLAGS_HI_BYTE;
        else if (pos == POS_FLAGS_LO) eb = FLAGS_LO_BYTE;
        else if (pos == POS_QD_HI || pos == POS_QD_LO) begin
          if (b != 8'h00) qd_nonzero = 1'b1;
        end else if (pos == POS_AN_HI) eb = 8'h00;
        else if (pos == POS_AN_LO) eb = ANSWER_COUNT;
        else if (pos >= POS_NS_HI) eb = 8'h00;
      end else if (!name_done) begin
        // walk the name's length labels
        echo = 1'b1;
        if (pos == label_pos) begin
          if (b == 8'h00) begin
            name_done = 1'b1;
            nx = pos + QTAIL_LEN;
            if (nx > PAYLOAD_LIMIT + 1) nx = PAYLOAD_LIMIT + 1;
            q_end = 10'(nx);
          end else begin
            nx = pos + b + 1;
            if (nx > PAYLOAD_LIMIT) nx = PAYLOAD_LIMIT;
            label_pos = 10'(nx);
          end
        end
      end else if (pos < q_end) begin
        echo = 1'b1;
      end
      byte_pos = 10'(pos + 1);
    end
    if (!last) begin
      if (echo) begin
        reply_step[n] = '{eb, 1'b0, 1'b0};
        n++;
      end
      return n;
    end
    // final byte: drop marker or echo plus answer record
    len    = byte_pos;
    dropit = len < HEADER_LEN || !qd_nonzero || !name_done || q_end > len;
    clear_query_state();
    if (dropit) begin
      reply_step[0] = '{8'h00, 1'b1, 1'b1};
      return 1;
    end
    if (echo) begin
      reply_step[n] = '{eb, 1'b0, 1'b0};
      n++;
    end
    record = {ANSWER_HEAD, answer_addr_model};
    for (i = 0; i < ANSWER_LEN; i++) begin
      reply_step[n] = '{record[127 - 8 * i -: 8], i == ANSWER_LEN - 1, 1'b0};
      n++;
    end
    return n;
  endfunction

  function automatic void report_failure(input string what, input reply_t want,
                                         input reply_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t %s: expected byte %h last %b drop %b, got byte %h last %b drop %b",
               $realtime, what, want.data, want.last, want.drop, got.data, got.last,
               got.drop);
  endfunction

  // random query of the given kind into query_bytes
  function automatic void build_query(input query_kind_e kind);
    int n_labels;
    int len;
    int pad;
    int cut;
    query_bytes.delete();
    if (kind == QK_NOISE) begin
      repeat ($urandom_range(1, 20)) query_bytes.push_back(8'($urandom));
      return;
    end
    repeat (HEADER_LEN) query_bytes.push_back(8'($urandom));
    if (kind == QK_NO_QUESTION) begin
      query_bytes[POS_QD_HI] = 8'h00;
      query_bytes[POS_QD_LO] = 8'h00;
    end else begin
      if ($urandom_range(2) == 0) query_bytes[POS_QD_HI] = 8'h00;
      if (query_bytes[POS_QD_HI] == 8'h00 && query_bytes[POS_QD_LO] == 8'h00)
        query_bytes[POS_QD_LO] = 8'h01;
    end
    if (kind == QK_FAR_LABEL) begin
      query_bytes.push_back(8'($urandom_range(200, 255)));
      repeat ($urandom_range(0, 8)) query_bytes.push_back(8'($urandom));
      return;
    end
    n_labels = $urandom_range(0, 3);
    repeat (n_labels) begin
      len = $urandom_range(1, 6);
      query_bytes.push_back(8'(len));
      repeat (len) query_bytes.push_back(8'($urandom));
    end
    query_bytes.push_back(8'h00);
    repeat (4) query_bytes.push_back(8'($urandom));
    pad = ($urandom_range(3) == 0) ? $urandom_range(1, 4) : 0;
    repeat (pad) query_bytes.push_back(8'($urandom));
    if (kind == QK_TRUNCATED) begin
      cut = $urandom_range(1, query_bytes.size() - 1);
      while (query_bytes.size() > cut) void'(query_bytes.pop_back());
    end
  endfunction

  // offer one query byte, with random idle cycles before it
  task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                           input reply_t typed_reply);
    int n;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.in_last <= last;
    do @(posedge clk); while (!in_ch.ready);
    n = predict_reply(b, last);
    if (typed) begin
      expected_replies.push_back(typed_reply);
    end else begin
      for (int i = 0; i < n; i++) expected_replies.push_back(reply_step[i]);
    end
  endtask

  task automatic send_query(input query_kind_e kind);
    build_query(kind);
    foreach (query_bytes[i])
      send_byte(query_bytes[i], i == query_bytes.size() - 1, 1'b0, '0);
  endtask

  // random mix, mostly well-formed queries
  task automatic run_queries(input int item_goal);
    int          sent;
    int          pick;
    query_kind_e kind;
    sent = 0;
    while (sent < item_goal) begin
      pick = $urandom_range(99);
      if (pick < 60) kind = QK_GOOD;
      else if (pick < 70) kind = QK_NO_QUESTION;
      else if (pick < 85) kind = QK_TRUNCATED;
      else if (pick < 90) kind = QK_FAR_LABEL;
      else kind = QK_NOISE;
      send_query(kind);
      sent += query_bytes.size();
    end
  endtask

  // stop offering until every reply item is back, then let the pipeline settle
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_answer_address(input logic [31:0] value);
    cfg_ch.valid          <= 1'b1;
    cfg_ch.answer_address <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid      <= 1'b0;
    answer_addr_model = value;
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // reply side ready, with random idling and the long hold-off
  initial begin
    out_ch.ready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // reply checker
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen_reply = '{out_ch.out_byte, out_ch.out_last, out_ch.drop};
      if (expected_replies.size() == 0) begin
        report_failure("reply item with none expected", '0, seen_reply);
      end else begin
        want_reply = expected_replies.pop_front();
        if (seen_reply.data !== want_reply.data || seen_reply.last !== want_reply.last ||
            seen_reply.drop !== want_reply.drop)
          report_failure("reply item mismatch", want_reply, seen_reply);
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  // main sequence
  initial begin
    rst_n                 <= 1'b0;
    in_ch.valid           <= 1'b0;
    in_ch.in_byte         <= 8'h00;
    in_ch.in_last         <= 1'b0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.answer_address <= 32'h0;
    mismatch_count    = 0;
    quiet_cycles      = 0;
    tx_idle_pct       = 0;
    rx_idle_pct       = 0;
    hold_req          = 1'b0;
    answer_addr_model = 32'h0;
    clear_query_state();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed queries, answer address still at its reset value
    foreach (query_table[i])
      send_byte(query_table[i].data, query_table[i].last, query_table[i].typed,
                query_table[i].reply);
    wait_drained();

    // phase one: all ones address, a long reply stall, then a random mix
    write_answer_address(32'hFFFF_FFFF);
    tx_idle_pct = 25;
    rx_idle_pct = 58;
    hold_req = 1'b1;
    send_query(QK_GOOD);
    wait_drained();
    run_queries(20);
    wait_drained();

    // phase two: random address, idling swapped
    write_answer_address($urandom);
    tx_idle_pct = 58;
    rx_idle_pct = 25;
    run_queries(25);
    wait_drained();

    // phase three: zero address, no idling
    write_answer_address(32'h0);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_queries(25);
    wait_drained();

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
